// ----- rtl/core/kwhm_pkg.sv -----
package kwhm_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int VALUE_BITS  = 32;
    localparam int SRC_BITS    = $clog2(MAX_SOURCES);
    localparam int CNT_BITS    = $clog2(MAX_SOURCES + 1);

    localparam logic signed [VALUE_BITS-1:0] INT_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    localparam logic OP_VALUE = 1'b0;
    localparam logic OP_END   = 1'b1;

    typedef struct packed {
        logic                         operation;
        logic [SRC_BITS-1:0]          source;
        logic signed [VALUE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] merged_value;
        logic [SRC_BITS-1:0]          from_source;
        logic                         dropped;
    } t_out_item;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] val;
        logic [SRC_BITS-1:0]          src;
    } t_entry;

    typedef struct packed {
        logic   clear;
        logic   push;
        logic   pop;
        t_entry entry;
    } t_heap_cmd;

    typedef struct packed {
        logic                busy;
        logic [CNT_BITS-1:0] count;
        t_entry              popped;
    } t_heap_status;

    // equal values order by ascending source index
    function automatic logic entry_less(t_entry a, t_entry b);
        logic lt;
        if (a.val != b.val) begin
            lt = (a.val < b.val);
        end else begin
            lt = (a.src < b.src);
        end
        return lt;
    endfunction

endpackage

// ----- rtl/core/kwhm_heap.sv -----
module kwhm_heap (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  kwhm_pkg::t_heap_cmd     i_cmd,
    output kwhm_pkg::t_heap_status  o_status
);

    localparam logic [2:0] H_IDLE     = 3'd0;
    localparam logic [2:0] H_PSH_RD   = 3'd1;
    localparam logic [2:0] H_PSH_CMP  = 3'd2;
    localparam logic [2:0] H_POP_TOP  = 3'd3;
    localparam logic [2:0] H_POP_LAST = 3'd4;
    localparam logic [2:0] H_DN_L     = 3'd5;
    localparam logic [2:0] H_DN_R     = 3'd6;
    localparam logic [2:0] H_DN_C     = 3'd7;

    localparam int SB = kwhm_pkg::SRC_BITS;
    localparam int CB = kwhm_pkg::CNT_BITS;

    kwhm_pkg::t_entry r_mem [kwhm_pkg::MAX_SOURCES];
    kwhm_pkg::t_entry r_rd;

    logic [2:0]       r_state, n_state;
    logic [CB-1:0]    r_cnt, n_cnt;
    logic [SB-1:0]    r_idx, n_idx;
    kwhm_pkg::t_entry r_x, n_x;
    kwhm_pkg::t_entry r_best, n_best;
    logic             r_bsel, n_bsel;
    kwhm_pkg::t_entry r_pop, n_pop;

    logic             mem_we;
    logic [SB-1:0]    mem_waddr;
    logic [SB-1:0]    mem_raddr;
    kwhm_pkg::t_entry mem_wdata;

    kwhm_pkg::t_entry cmp_a, cmp_b;
    logic             cmp_lt;

    logic [SB-1:0]    parent;
    logic [SB:0]      left;
    logic [SB:0]      right;

    assign cmp_lt = kwhm_pkg::entry_less(cmp_a, cmp_b);
    assign parent = SB'((r_idx - SB'(1)) >> 1);
    assign left   = {r_idx, 1'b1};
    assign right  = left + (SB+1)'(1);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_x       = r_x;
        n_best    = r_best;
        n_bsel    = r_bsel;
        n_pop     = r_pop;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_x;
        mem_raddr = '0;
        cmp_a     = r_x;
        cmp_b     = r_rd;
        case (r_state)
            H_IDLE: begin
                if (i_cmd.push) begin
                    n_x     = i_cmd.entry;
                    n_idx   = r_cnt[SB-1:0];
                    n_cnt   = r_cnt + CB'(1);
                    n_state = H_PSH_RD;
                end else if (i_cmd.pop) begin
                    mem_raddr = '0;
                    n_cnt     = r_cnt - CB'(1);
                    n_state   = H_POP_TOP;
                end
            end
            H_PSH_RD: begin
                if (r_idx == '0) begin
                    mem_we  = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    mem_raddr = parent;
                    n_state   = H_PSH_CMP;
                end
            end
            H_PSH_CMP: begin
                mem_we = 1'b1;
                if (cmp_lt) begin
                    // move parent down, climb
                    mem_wdata = r_rd;
                    n_idx     = parent;
                    n_state   = H_PSH_RD;
                end else begin
                    n_state = H_IDLE;
                end
            end
            H_POP_TOP: begin
                n_pop     = r_rd;
                mem_raddr = r_cnt[SB-1:0];
                n_state   = H_POP_LAST;
            end
            H_POP_LAST: begin
                n_x     = r_rd;
                n_idx   = '0;
                n_state = H_DN_L;
            end
            H_DN_L: begin
                if (left >= (SB+1)'(r_cnt)) begin
                    mem_we  = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    mem_raddr = left[SB-1:0];
                    n_state   = H_DN_R;
                end
            end
            H_DN_R: begin
                cmp_a = r_rd;
                cmp_b = r_x;
                if (right < (SB+1)'(r_cnt)) begin
                    n_best    = cmp_lt ? r_rd : r_x;
                    n_bsel    = cmp_lt;
                    mem_raddr = right[SB-1:0];
                    n_state   = H_DN_C;
                end else if (cmp_lt) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd;
                    n_idx     = left[SB-1:0];
                    n_state   = H_DN_L;
                end else begin
                    mem_we  = 1'b1;
                    n_state = H_IDLE;
                end
            end
            H_DN_C: begin
                cmp_a  = r_rd;
                cmp_b  = r_best;
                mem_we = 1'b1;
                if (cmp_lt) begin
                    mem_wdata = r_rd;
                    n_idx     = right[SB-1:0];
                    n_state   = H_DN_L;
                end else if (r_bsel) begin
                    mem_wdata = r_best;
                    n_idx     = left[SB-1:0];
                    n_state   = H_DN_L;
                end else begin
                    n_state = H_IDLE;
                end
            end
            default: begin
                n_state = H_IDLE;
            end
        endcase
        if (i_cmd.clear) begin
            n_state = H_IDLE;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_idx  <= n_idx;
        r_x    <= n_x;
        r_best <= n_best;
        r_bsel <= n_bsel;
        r_pop  <= n_pop;
    end

    assign o_status.busy   = (r_state != H_IDLE);
    assign o_status.count  = r_cnt;
    assign o_status.popped = r_pop;

endmodule

// ----- rtl/core/kway_heap_merge.sv -----
// K-way merge of up to 16 sorted signed streams through a min-heap holding one
// head per source. Each transfer in is a value or an end marker for one source;
// each result names the source to read next. A value that enters the heap passes
// the heap engine: one heap RAM with registered read and separate read and write
// addresses, and one shared comparator, stepping sift-up through a parent read and
// a compare per level and sift-down through a left read, a right read and a compare
// per level, plus accept, check and output load. An ignored item leaves the block
// idle, and a result waits while the output register is full and stalled. The
// block takes one item at a time (o_stall high while busy); a waiting result sits
// in the output register while the next item runs. Writing source_count restarts
// the merge; there is no clearing pass.
module kway_heap_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  kwhm_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output kwhm_pkg::t_out_item  o_data,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam int CB = kwhm_pkg::CNT_BITS;
    localparam int NS = kwhm_pkg::MAX_SOURCES;

    logic [2:0]                             r_state, n_state;
    logic [CB-1:0]                          r_eff;
    logic [CB-1:0]                          r_active;
    logic [NS-1:0]                          r_ended;
    logic [NS-1:0]                          r_present;
    logic signed [kwhm_pkg::VALUE_BITS-1:0] r_last;
    kwhm_pkg::t_out_item                    r_res;
    logic                                   r_out_valid;
    kwhm_pkg::t_out_item                    r_out;

    kwhm_pkg::t_heap_cmd    heap_cmd;
    kwhm_pkg::t_heap_status heap_st;

    logic          in_xfer;
    logic          ignore;
    logic          is_end;
    logic          is_drop;
    logic          pop_due;
    logic          out_load;
    logic [CB-1:0] cfg_eff;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall && !i_cfg_we;
    assign ignore   = ({1'b0, i_data.source} >= r_eff) || r_ended[i_data.source]
                      || r_present[i_data.source];
    assign is_end   = (i_data.operation == kwhm_pkg::OP_END);
    assign is_drop  = !is_end && (i_data.value < r_last);
    assign pop_due  = (heap_st.count != '0) && (heap_st.count >= r_active);
    assign out_load = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    // zero acts as one, above the maximum clamps
    assign cfg_eff = (i_cfg_wdata == '0) ? CB'(1) :
                     ({1'b0, i_cfg_wdata} > 6'(NS)) ? CB'(NS) : CB'(i_cfg_wdata);

    assign heap_cmd.clear     = i_cfg_we;
    assign heap_cmd.push      = in_xfer && !ignore && !is_end && !is_drop;
    assign heap_cmd.pop       = (r_state == S_CHECK) && pop_due && !i_cfg_we;
    assign heap_cmd.entry.val = i_data.value;
    assign heap_cmd.entry.src = i_data.source;

    kwhm_heap u_heap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (heap_cmd),
        .o_status (heap_st)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && !ignore) begin
                    if (is_end) begin
                        n_state = S_CHECK;
                    end else if (is_drop) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (!heap_st.busy) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = pop_due ? S_POP : S_IDLE;
            end
            S_POP: begin
                if (!heap_st.busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_eff       <= CB'(NS);
            r_active    <= CB'(NS);
            r_ended     <= '0;
            r_present   <= '0;
            r_last      <= kwhm_pkg::INT_MIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_eff     <= cfg_eff;
                r_active  <= cfg_eff;
                r_ended   <= '0;
                r_present <= '0;
                r_last    <= kwhm_pkg::INT_MIN;
            end else begin
                if (in_xfer && !ignore) begin
                    if (is_end) begin
                        r_ended[i_data.source] <= 1'b1;
                        if (r_active != '0) begin
                            r_active <= r_active - CB'(1);
                        end
                    end else if (!is_drop) begin
                        r_present[i_data.source] <= 1'b1;
                    end
                end
                if ((r_state == S_POP) && !heap_st.busy) begin
                    r_present[heap_st.popped.src] <= 1'b0;
                    r_last                        <= heap_st.popped.val;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: hold drop or popped head until the output register frees
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && in_xfer) begin
            r_res.merged_value <= i_data.value;
            r_res.from_source  <= i_data.source;
            r_res.dropped      <= 1'b1;
        end else if ((r_state == S_POP) && !heap_st.busy) begin
            r_res.merged_value <= heap_st.popped.val;
            r_res.from_source  <= heap_st.popped.src;
            r_res.dropped      <= 1'b0;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- rtl/core/kwhm_checker.sv -----
module kwhm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input kwhm_pkg::t_out_item  o_data,
    input logic                 i_cfg_we
);

    logic signed [kwhm_pkg::VALUE_BITS-1:0] r_merged;
    logic                                   out_xfer;

    assign out_xfer = o_valid && !i_stall;

    // track last merged value seen at the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_merged <= kwhm_pkg::INT_MIN;
        end else if (out_xfer && !o_data.dropped) begin
            r_merged <= o_data.merged_value;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_stall)
        else $error("not ready after restart");

    a_merge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !o_data.dropped |-> o_data.merged_value >= r_merged)
        else $error("merged output out of order");

    a_drop_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_data.dropped |-> o_data.merged_value < r_merged)
        else $error("dropped value not below last merged");

endmodule

bind kway_heap_merge kwhm_checker u_kwhm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_data      (o_data),
    .i_cfg_we    (i_cfg_we)
);

// ----- sim/kwhm_merge_checker.sv -----
`timescale 1ns / 100ps
module kwhm_merge_checker
    import kwhm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_in_item               i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_out_item              i_out_data,
    input  logic                   i_cfg_we,
    input  logic [4:0]             i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output logic [MAX_SOURCES-1:0] o_need_mask
);

    typedef struct packed {
        t_entry [MAX_SOURCES-1:0]     heap;
        logic [CNT_BITS-1:0]          fill;
        logic signed [VALUE_BITS-1:0] floor_val;
        logic [MAX_SOURCES-1:0]       ended;
        logic [MAX_SOURCES-1:0]       present;
        logic [CNT_BITS-1:0]          active;
        logic [CNT_BITS-1:0]          eff;
    } t_merge_state;

    t_merge_state merge_st;
    t_merge_state look_st;
    logic         look_emit;
    t_out_item    look_res;
    t_out_item    merged_q[$];

    function automatic logic [CNT_BITS-1:0] clamp_count(logic [4:0] raw);
        if (raw == 5'd0) return CNT_BITS'(1);
        if (raw > MAX_SOURCES) return CNT_BITS'(MAX_SOURCES);
        return raw[CNT_BITS-1:0];
    endfunction

    function automatic t_merge_state restart_state(logic [CNT_BITS-1:0] eff);
        t_merge_state st;
        st = '0;
        st.floor_val = INT_MIN;
        st.active = eff;
        st.eff = eff;
        return st;
    endfunction

    // signed order first, then ascending source for equal values
    function automatic logic head_before(t_entry a, t_entry b);
        if ($signed(a.val) != $signed(b.val)) return $signed(a.val) < $signed(b.val);
        return a.src < b.src;
    endfunction

    function automatic void merge_step(
        input  t_merge_state cur,
        input  t_in_item     it,
        output t_merge_state nxt,
        output logic         emit,
        output t_out_item    res
    );
        t_merge_state st;
        t_entry       tmp;
        t_entry       head;
        int           i, p, l, r, m;
        logic         done;
        logic         took;
        st = cur;
        emit = 1'b0;
        res = '0;
        took = 1'b0;
        if (it.source < st.eff && !st.ended[it.source] && !st.present[it.source]) begin
            if (it.operation == OP_END) begin
                st.ended[it.source] = 1'b1;
                if (st.active != 0) st.active = st.active - 1'b1;
                took = 1'b1;
            end else if ($signed(it.value) < $signed(st.floor_val)) begin
                // out of order: report and leave the heap alone
                emit = 1'b1;
                res.merged_value = it.value;
                res.from_source = it.source;
                res.dropped = 1'b1;
            end else begin
                i = int'(st.fill);
                tmp.val = it.value;
                tmp.src = it.source;
                st.heap[i] = tmp;
                st.fill = st.fill + 1'b1;
                st.present[it.source] = 1'b1;
                done = 1'b0;
                for (int lvl = 0; lvl <= SRC_BITS; lvl++) begin
                    if (!done && i > 0) begin
                        p = (i - 1) / 2;
                        if (head_before(st.heap[i], st.heap[p])) begin
                            tmp = st.heap[i];
                            st.heap[i] = st.heap[p];
                            st.heap[p] = tmp;
                            i = p;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                took = 1'b1;
            end
            if (took && st.fill != 0 && st.fill >= st.active) begin
                head = st.heap[0];
                st.fill = st.fill - 1'b1;
                st.heap[0] = st.heap[st.fill];
                i = 0;
                done = 1'b0;
                for (int lvl = 0; lvl <= SRC_BITS; lvl++) begin
                    if (!done) begin
                        l = 2 * i + 1;
                        r = l + 1;
                        m = i;
                        if (l < int'(st.fill) && head_before(st.heap[l], st.heap[m])) m = l;
                        if (r < int'(st.fill) && head_before(st.heap[r], st.heap[m])) m = r;
                        if (m == i) begin
                            done = 1'b1;
                        end else begin
                            tmp = st.heap[i];
                            st.heap[i] = st.heap[m];
                            st.heap[m] = tmp;
                            i = m;
                        end
                    end
                end
                st.present[head.src] = 1'b0;
                st.floor_val = head.val;
                emit = 1'b1;
                res.merged_value = head.val;
                res.from_source = head.src;
                res.dropped = 1'b0;
            end
        end
        nxt = st;
    endfunction

    // state as it stands after the current edge, so the stimulus can plan ahead
    always_comb begin
        look_st = merge_st;
        look_emit = 1'b0;
        look_res = '0;
        if (!i_rst_n) begin
            look_st = restart_state(CNT_BITS'(MAX_SOURCES));
        end else if (i_cfg_we) begin
            look_st = restart_state(clamp_count(i_cfg_wdata));
        end else if (i_in_valid && !i_in_stall) begin
            merge_step(merge_st, i_in_data, look_st, look_emit, look_res);
        end
        for (int s = 0; s < MAX_SOURCES; s++) begin
            o_need_mask[s] = (s < int'(look_st.eff)) && !look_st.ended[s] && !look_st.present[s];
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            merge_st <= restart_state(CNT_BITS'(MAX_SOURCES));
            merged_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (merged_q.size() == 0) begin
                    $display("%0t: unexpected result value %0d source %0d dropped %0b",
                             $time, i_out_data.merged_value, i_out_data.from_source,
                             i_out_data.dropped);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = merged_q.pop_front();
                    if (i_out_data !== want) begin
                        $display("%0t: mismatch, expected value %0d source %0d dropped %0b, %s",
                                 $time, want.merged_value, want.from_source, want.dropped,
                                 $sformatf("got value %0d source %0d dropped %0b",
                                           i_out_data.merged_value, i_out_data.from_source,
                                           i_out_data.dropped));
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            merge_st <= look_st;
            if (look_emit) merged_q.push_back(look_res);
            o_pending <= merged_q.size();
        end
    end

endmodule

// ----- sim/tb_kway_heap_merge.sv -----
`timescale 1ns / 100ps
module tb_kway_heap_merge;
    import kwhm_pkg::*;

    localparam int HOLD_LEN      = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 104;
    localparam int NUM_PHASES    = 9;

    localparam logic signed [VALUE_BITS-1:0] INT_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_stall = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [4:0] i_cfg_wdata = '0;
    t_in_item   i_data = '0;
    logic       o_stall;
    logic       o_valid;
    t_out_item  o_data;

    int                     fail_count;
    int                     pending;
    logic [MAX_SOURCES-1:0] need_mask;

    int send_gap_pct = 13;
    int recv_gap_pct = 53;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;

    logic signed [VALUE_BITS-1:0] cursor [MAX_SOURCES];

    kway_heap_merge DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    kwhm_merge_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_need_mask  (need_mask)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stall, or a long hold-off when the stimulus asks for one
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_ask != hold_seen) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_seen <= hold_ask;
        end else begin
            i_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("kway_heap_merge verification failed");
        $finish;
    end

    function automatic t_in_item mk_item(logic op, int src, logic signed [VALUE_BITS-1:0] val);
        t_in_item it;
        it.operation = op;
        it.source = src[SRC_BITS-1:0];
        it.value = val;
        return it;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] sat_add(
        logic signed [VALUE_BITS-1:0] a,
        logic [VALUE_BITS-1:0]        b
    );
        longint sum;
        sum = longint'(a) + longint'(b);
        if (sum > longint'(INT_MAX)) return INT_MAX;
        return sum[VALUE_BITS-1:0];
    endfunction

    function automatic int pick_needed(logic [MAX_SOURCES-1:0] mask);
        int start, s;
        start = $urandom_range(MAX_SOURCES - 1);
        for (int n = 0; n < MAX_SOURCES; n++) begin
            s = (start + n) % MAX_SOURCES;
            if (mask[s]) return s;
        end
        return start;
    endfunction

    // called on a clock edge; returns on the edge of the transfer with valid still high
    task automatic send_item(input t_in_item it);
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [4:0] count_raw);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= count_raw;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic seed_cursors();
        logic signed [VALUE_BITS-1:0] base;
        int                           sel;
        sel = $urandom_range(9);
        if (sel == 0) base = INT_MIN;
        else if (sel == 1) base = INT_MAX - 500;
        else base = $urandom;
        for (int s = 0; s < MAX_SOURCES; s++) begin
            if ($urandom_range(3) == 0) cursor[s] = base;
            else cursor[s] = sat_add(base, $urandom_range(0, 2000));
        end
    endtask

    task automatic restart_merge(input logic [4:0] count_raw);
        wait_idle();
        write_count(count_raw);
        seed_cursors();
    endtask

    task automatic run_phase(input logic [4:0] count_raw, input bit with_hold,
                             input bit with_pause);
        t_in_item it;
        int       s, sel;
        restart_merge(count_raw);
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            // every source ended: start over with the same count
            if (need_mask == 0) restart_merge(count_raw);
            if (with_hold && k == PHASE_ITEMS / 3) hold_ask <= hold_ask + 1;
            if (with_pause && k == 2 * PHASE_ITEMS / 3) wait_idle();
            s = pick_needed(need_mask);
            sel = $urandom_range(99);
            if (sel < 6) begin
                it = mk_item(1'($urandom_range(1)), $urandom_range(MAX_SOURCES - 1), $urandom);
                if (it.operation == OP_VALUE && $signed(it.value) > cursor[it.source]) begin
                    cursor[it.source] = it.value;
                end
            end else if (sel < 10) begin
                // below what this source already delivered
                if ($urandom_range(3) == 0) it = mk_item(OP_VALUE, s, INT_MIN);
                else it = mk_item(OP_VALUE, s, cursor[s] - 1 - $urandom_range(0, 100));
            end else if (sel < 11) begin
                it = mk_item(OP_END, s, $urandom);
            end else begin
                sel = $urandom_range(99);
                if (sel < 70) cursor[s] = sat_add(cursor[s], $urandom_range(1, 100));
                else if (sel < 95) cursor[s] = cursor[s];
                else cursor[s] = sat_add(cursor[s], $urandom);
                it = mk_item(OP_VALUE, s, cursor[s]);
            end
            send_item(it);
        end
        // drain: end every source, then offer items that must be ignored
        while (need_mask != 0) begin
            send_item(mk_item(OP_END, pick_needed(need_mask), $urandom));
        end
        repeat (3) begin
            send_item(mk_item(1'($urandom_range(1)), $urandom_range(MAX_SOURCES - 1),
                              $urandom));
        end
    endtask

    initial begin
        logic [4:0] counts [NUM_PHASES];
        t_in_item   directed [$];
        counts[0] = 5'd16;
        counts[1] = 5'd1;
        counts[2] = 5'd0;
        counts[3] = 5'd31;
        counts[4] = 5'd2;
        counts[5] = 5'($urandom_range(1, 16));
        counts[6] = 5'd16;
        counts[7] = 5'd5;
        counts[8] = 5'($urandom_range(0, 31));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // three sources: ties, drops, ignored items, ends, all ended
        directed.push_back(mk_item(OP_VALUE, 0, INT_MIN));
        directed.push_back(mk_item(OP_VALUE, 0, 5));
        directed.push_back(mk_item(OP_END, 0, 0));
        directed.push_back(mk_item(OP_VALUE, 5, 7));
        directed.push_back(mk_item(OP_VALUE, 15, INT_MIN));
        directed.push_back(mk_item(OP_VALUE, 1, INT_MAX));
        directed.push_back(mk_item(OP_VALUE, 2, -1));
        directed.push_back(mk_item(OP_VALUE, 0, INT_MIN));
        directed.push_back(mk_item(OP_VALUE, 0, -1));
        directed.push_back(mk_item(OP_VALUE, 0, -2));
        directed.push_back(mk_item(OP_VALUE, 0, 0));
        directed.push_back(mk_item(OP_END, 2, INT_MAX));
        directed.push_back(mk_item(OP_VALUE, 2, 3));
        directed.push_back(mk_item(OP_VALUE, 0, INT_MAX));
        directed.push_back(mk_item(OP_VALUE, 0, INT_MIN));
        directed.push_back(mk_item(OP_END, 0, -1));
        directed.push_back(mk_item(OP_END, 1, 0));
        directed.push_back(mk_item(OP_VALUE, 1, 9));
        directed.push_back(mk_item(OP_END, 1, 0));
        write_count(5'd3);
        foreach (directed[n]) send_item(directed[n]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                send_gap_pct <= 53;
                recv_gap_pct <= 13;
            end else if (p == 6) begin
                send_gap_pct <= 0;
                recv_gap_pct <= 0;
            end
            run_phase(counts[p], (p == 1 || p == 7), (p == 2 || p == 5));
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("kway_heap_merge verification clean");
        end else begin
            $display("kway_heap_merge verification failed");
        end
        $finish;
    end

endmodule
